[rtl/d8fd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the D8 flow direction block.
package d8fd_pkg;

    // Geometry and word widths.
    localparam int MAX_WIDTH      = 1024;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = 16;
    localparam int WIDTH_CFG_BITS = 11;
    localparam int OFFSETS_BITS   = 32;
    localparam int SAMPLE_BITS    = 16;
    localparam int HEIGHT_BITS    = 16;
    localparam int WEIGHT_BITS    = HEIGHT_BITS + 16;
    localparam int DIR_BITS       = 3;
    localparam int NUM_DIRS       = 8;
    localparam int WIN_CELLS      = 9;
    localparam int NUM_JOBS       = 4;
    localparam int JOB_BITS       = 2;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS = QPTR_BITS + 1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_WIDTH       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_HEIGHT      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NEIGHBOR_OFFSETS = 2'd2;

    localparam logic [WIDTH_CFG_BITS-1:0] GRID_WIDTH_RESET  = 11'd1024;
    localparam logic [ROW_BITS-1:0]       GRID_HEIGHT_RESET = 16'd1024;
    localparam logic [OFFSETS_BITS-1:0]   OFFSETS_RESET     = 32'hDCF3_7451;

    // Step codes of one offset entry half.
    localparam logic [1:0] STEP_PLUS  = 2'd1;
    localparam logic [1:0] STEP_MINUS = 2'd3;

    // 1/sqrt(2) in Q16, rounded.
    localparam logic [15:0] Q16_INV_SQRT2 = 16'd46341;

    // Result jobs of one word, in emission order.
    localparam logic [JOB_BITS-1:0] JOB_PREV_CENTER = 2'd0; // cell (x-1, z-1)
    localparam logic [JOB_BITS-1:0] JOB_PREV_EDGE   = 2'd1; // cell (x, z-1), row end
    localparam logic [JOB_BITS-1:0] JOB_LAST_CENTER = 2'd2; // cell (x-1, z), last row
    localparam logic [JOB_BITS-1:0] JOB_LAST_EDGE   = 2'd3; // cell (x, z), grid end

    typedef logic [HEIGHT_BITS-1:0] t_height;

    // One classified word as handed from the front to the back.
    typedef struct packed {
        logic [WIN_CELLS-1:0][HEIGHT_BITS-1:0] win;
        logic [COL_BITS-1:0]                   x;
        logic [ROW_BITS-1:0]                   z;
        logic                                  x_is_one;
        logic                                  z_is_one;
        logic [NUM_JOBS-1:0]                   jobs;
    } t_entry;

endpackage

[rtl/d8fd_if.sv]
`timescale 1ns / 1ps
// Stream interfaces for height words in and flow direction words out.
interface d8fd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [d8fd_pkg::SAMPLE_BITS-1:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

interface d8fd_result_if;
    logic                              valid;
    logic                              ready;
    logic [d8fd_pkg::COL_BITS-1:0]     cell_column;
    logic [d8fd_pkg::ROW_BITS-1:0]     cell_row;
    logic [d8fd_pkg::DIR_BITS-1:0]     flow_direction;
    logic                              is_sink;
    logic                              last_of_run;
    logic                              grid_done;

    modport source (output valid, output cell_column, output cell_row,
                    output flow_direction, output is_sink, output last_of_run,
                    output grid_done, input ready);
    modport sink   (input valid, input cell_column, input cell_row,
                    input flow_direction, input is_sink, input last_of_run,
                    input grid_done, output ready);
endinterface

[rtl/d8fd_front.sv]
`timescale 1ns / 1ps
// Front end: raster counters, line buffer, 3x3 window and job classification.
module d8fd_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    d8fd_sample_if.sink                           i_sample,
    input  logic [d8fd_pkg::WIDTH_CFG_BITS-1:0]   i_grid_width,
    input  logic [d8fd_pkg::ROW_BITS-1:0]         i_grid_height,
    input  logic [d8fd_pkg::QCOUNT_BITS-1:0]      i_q_count,
    output logic                                  o_push,
    output d8fd_pkg::t_entry                      o_entry
);
    import d8fd_pkg::*;

    logic [WIDTH_CFG_BITS-1:0] w_eff;
    logic [ROW_BITS-1:0]       h_eff;
    logic                      accept;
    logic [COL_BITS-1:0]       x;
    logic [ROW_BITS-1:0]       z;
    logic [ROW_BITS:0]         row_adv;
    logic                      x_last;
    logic                      z_last;
    logic [NUM_JOBS-1:0]       jobs;
    logic [COL_BITS-1:0]       n_col;
    logic [ROW_BITS-1:0]       n_row;
    t_height                   older;
    t_height                   newer;
    logic [WIN_CELLS-1:0][HEIGHT_BITS-1:0] n_win;

    logic [COL_BITS-1:0]       r_col;
    logic [ROW_BITS-1:0]       r_row;
    logic                      r_s1_valid;
    t_height                   r_s1_sample;
    logic [COL_BITS-1:0]       r_s1_x;
    logic [ROW_BITS-1:0]       r_s1_z;
    logic                      r_s1_x_is_one;
    logic                      r_s1_z_is_one;
    logic [NUM_JOBS-1:0]       r_s1_jobs;
    logic [WIN_CELLS-1:0][HEIGHT_BITS-1:0] r_win;

    // Each entry holds the row two back in the upper half and the row one back below.
    logic [2*HEIGHT_BITS-1:0]  r_line_mem [MAX_WIDTH];
    logic [2*HEIGHT_BITS-1:0]  r_line_rd;

    // The word in stage one may still be pushed into the queue, so count it as taken.
    assign i_sample.ready = (i_q_count + QCOUNT_BITS'(r_s1_valid)) < QCOUNT_BITS'(QUEUE_DEPTH);
    assign accept         = i_sample.valid && i_sample.ready;

    always_comb begin
        w_eff = i_grid_width;
        if (i_grid_width < WIDTH_CFG_BITS'(2)) begin
            w_eff = WIDTH_CFG_BITS'(2);
        end else if (i_grid_width > WIDTH_CFG_BITS'(MAX_WIDTH)) begin
            w_eff = WIDTH_CFG_BITS'(MAX_WIDTH);
        end
        h_eff = (i_grid_height < ROW_BITS'(2)) ? ROW_BITS'(2) : i_grid_height;
    end

    // Position of the incoming cell; a shrunken width or height takes effect here.
    always_comb begin
        if (WIDTH_CFG_BITS'(r_col) >= w_eff) begin
            x       = '0;
            row_adv = (ROW_BITS+1)'(r_row) + (ROW_BITS+1)'(1);
        end else begin
            x       = r_col;
            row_adv = (ROW_BITS+1)'(r_row);
        end
        z = (row_adv >= (ROW_BITS+1)'(h_eff)) ? '0 : row_adv[ROW_BITS-1:0];

        x_last = (WIDTH_CFG_BITS'(x) + WIDTH_CFG_BITS'(1)) == w_eff;
        z_last = ((ROW_BITS+1)'(z) + (ROW_BITS+1)'(1)) == (ROW_BITS+1)'(h_eff);

        jobs[JOB_PREV_CENTER] = (z != '0) && (x != '0);
        jobs[JOB_PREV_EDGE]   = (z != '0) && x_last;
        jobs[JOB_LAST_CENTER] = (z != '0) && z_last && (x != '0);
        jobs[JOB_LAST_EDGE]   = (z != '0) && z_last && x_last;

        n_col = x_last ? '0 : x + COL_BITS'(1);
        n_row = z;
        if (x_last) begin
            n_row = z_last ? '0 : z + ROW_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample   <= i_sample.height_sample[HEIGHT_BITS-1:0];
            r_s1_x        <= x;
            r_s1_z        <= z;
            r_s1_x_is_one <= (x == COL_BITS'(1));
            r_s1_z_is_one <= (z == ROW_BITS'(1));
            r_s1_jobs     <= jobs;
        end
    end

    // Read in the accept cycle, write back in the cycle after; neighboring words
    // always use different columns, so the two never collide.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line_rd <= r_line_mem[x];
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_x] <= {newer, r_s1_sample};
        end
    end

    assign older = r_line_rd[2*HEIGHT_BITS-1:HEIGHT_BITS];
    assign newer = r_line_rd[HEIGHT_BITS-1:0];

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = older;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = newer;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_sample;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_push           = r_s1_valid && (r_s1_jobs != '0);
    assign o_entry.win      = n_win;
    assign o_entry.x        = r_s1_x;
    assign o_entry.z        = r_s1_z;
    assign o_entry.x_is_one = r_s1_x_is_one;
    assign o_entry.z_is_one = r_s1_z_is_one;
    assign o_entry.jobs     = r_s1_jobs;

endmodule

[rtl/d8fd_queue.sv]
`timescale 1ns / 1ps
// Short queue of classified window entries between the front and the back.
module d8fd_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  d8fd_pkg::t_entry                 i_entry,
    input  logic                             i_pop,
    output logic                             o_valid,
    output d8fd_pkg::t_entry                 o_head,
    output logic [d8fd_pkg::QCOUNT_BITS-1:0] o_count
);
    import d8fd_pkg::*;

    t_entry                 r_slots [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   r_wr_ptr;
    logic [QPTR_BITS-1:0]   r_rd_ptr;
    logic [QCOUNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCOUNT_BITS'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCOUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_slots[r_rd_ptr];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < QCOUNT_BITS'(QUEUE_DEPTH))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue read while empty");

endmodule

[rtl/d8fd_back.sv]
`timescale 1ns / 1ps
// Back end: job sequencing, slope lanes, steepest-descent tree and output register.
module d8fd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [d8fd_pkg::OFFSETS_BITS-1:0]   i_offsets,
    input  logic                                i_head_valid,
    input  d8fd_pkg::t_entry                    i_head,
    output logic                                o_pop,
    d8fd_result_if.source                       o_result
);
    import d8fd_pkg::*;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                last;
        logic                grid_done;
    } t_tag;

    logic                      advance;
    logic                      issue;
    logic [NUM_JOBS-1:0]       pend;
    logic [JOB_BITS-1:0]       sel;
    logic [NUM_JOBS-1:0]       job_bit;
    logic                      last_job;
    logic                      col_shift;
    logic                      row_shift;
    logic                      no_left;
    logic                      no_right;
    logic                      no_top;
    logic                      no_bottom;
    t_tag                      n_a_tag;
    logic [WIN_CELLS-1:0][HEIGHT_BITS-1:0] patch;
    logic [NUM_DIRS-1:0][HEIGHT_BITS-1:0]  n_mag;
    logic [NUM_DIRS-1:0]       n_diag;
    logic [3:0][WEIGHT_BITS-1:0]           l1_w;
    logic [3:0][DIR_BITS-1:0]              l1_d;
    logic [1:0][WEIGHT_BITS-1:0]           l2_w;
    logic [1:0][DIR_BITS-1:0]              l2_d;
    logic [WEIGHT_BITS-1:0]    best_w;
    logic [DIR_BITS-1:0]       best_d;

    logic [NUM_JOBS-1:0]       r_taken;
    logic                      r_a_valid;
    t_tag                      r_a_tag;
    logic [NUM_DIRS-1:0][HEIGHT_BITS-1:0]  r_a_mag;
    logic [NUM_DIRS-1:0]       r_a_diag;
    logic                      r_b_valid;
    t_tag                      r_b_tag;
    logic [NUM_DIRS-1:0][WEIGHT_BITS-1:0]  r_b_weight;
    logic                      r_c_valid;
    t_tag                      r_c_tag;
    logic [1:0][WEIGHT_BITS-1:0]           r_c_weight;
    logic [1:0][DIR_BITS-1:0]              r_c_dir;
    logic                      r_out_valid;
    t_tag                      r_out_tag;
    logic [DIR_BITS-1:0]       r_out_dir;
    logic                      r_out_sink;

    // The whole back pipeline moves whenever the output register can take a word.
    assign advance = !r_out_valid || o_result.ready;
    assign issue   = advance && i_head_valid;

    // Lowest pending job of the head entry goes first.
    always_comb begin
        pend = i_head.jobs & ~r_taken;
        sel  = JOB_LAST_EDGE;
        if (pend[JOB_LAST_CENTER]) begin
            sel = JOB_LAST_CENTER;
        end
        if (pend[JOB_PREV_EDGE]) begin
            sel = JOB_PREV_EDGE;
        end
        if (pend[JOB_PREV_CENTER]) begin
            sel = JOB_PREV_CENTER;
        end
        job_bit  = NUM_JOBS'(1) << sel;
        last_job = (pend & ~job_bit) == '0;
    end

    assign o_pop = issue && last_job;

    // Window position of the cell and which sides of it fall off the grid.
    always_comb begin
        col_shift         = 1'b0;
        row_shift         = 1'b0;
        no_left           = 1'b0;
        no_right          = 1'b0;
        no_top            = 1'b0;
        no_bottom         = 1'b0;
        n_a_tag.col       = i_head.x;
        n_a_tag.row       = i_head.z;
        case (sel)
            JOB_PREV_CENTER: begin
                n_a_tag.col = i_head.x - COL_BITS'(1);
                n_a_tag.row = i_head.z - ROW_BITS'(1);
                no_left     = i_head.x_is_one;
                no_top      = i_head.z_is_one;
            end
            JOB_PREV_EDGE: begin
                col_shift   = 1'b1;
                n_a_tag.row = i_head.z - ROW_BITS'(1);
                no_right    = 1'b1;
                no_top      = i_head.z_is_one;
            end
            JOB_LAST_CENTER: begin
                row_shift   = 1'b1;
                n_a_tag.col = i_head.x - COL_BITS'(1);
                no_left     = i_head.x_is_one;
                no_bottom   = 1'b1;
            end
            JOB_LAST_EDGE: begin
                col_shift   = 1'b1;
                row_shift   = 1'b1;
                no_right    = 1'b1;
                no_bottom   = 1'b1;
            end
            default: begin
                col_shift   = 1'b0;
            end
        endcase
        n_a_tag.last      = last_job;
        n_a_tag.grid_done = (sel == JOB_LAST_EDGE);
    end

    // 3x3 neighborhood centered on the cell; places beyond the window read zero.
    always_comb begin
        for (int pr = 0; pr < 3; pr++) begin
            for (int pc = 0; pc < 3; pc++) begin
                patch[pr*3+pc] = '0;
                if ((pr + int'(row_shift) <= 2) && (pc + int'(col_shift) <= 2)) begin
                    patch[pr*3+pc] =
                        i_head.win[4'((pr + int'(row_shift)) * 3 + pc + int'(col_shift))];
                end
            end
        end
    end

    // One lane per offset entry: drop toward the neighbor, zero when it does not count.
    always_comb begin
        logic [3:0]           code;
        logic                 dxp;
        logic                 dxm;
        logic                 dzp;
        logic                 dzm;
        logic                 skip;
        logic [3:0]           nidx;
        logic [HEIGHT_BITS:0] delta;
        for (int i = 0; i < NUM_DIRS; i++) begin
            code  = i_offsets[4*i +: 4];
            dxp   = (code[1:0] == STEP_PLUS);
            dxm   = (code[1:0] == STEP_MINUS);
            dzp   = (code[3:2] == STEP_PLUS);
            dzm   = (code[3:2] == STEP_MINUS);
            skip  = (!dxp && !dxm && !dzp && !dzm) || (dxm && no_left) ||
                    (dxp && no_right) || (dzm && no_top) || (dzp && no_bottom);
            nidx  = (dzm ? 4'd0 : (dzp ? 4'd6 : 4'd3)) + (dxm ? 4'd0 : (dxp ? 4'd2 : 4'd1));
            delta = {patch[4][HEIGHT_BITS-1], patch[4]} -
                    {patch[nidx][HEIGHT_BITS-1], patch[nidx]};
            n_mag[i]  = '0;
            if (!skip && !delta[HEIGHT_BITS] && (delta != '0)) begin
                n_mag[i] = delta[HEIGHT_BITS-1:0];
            end
            n_diag[i] = (dxp || dxm) && (dzp || dzm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else if (issue) begin
            r_taken <= last_job ? '0 : (r_taken | job_bit);
        end
    end

    // Stage A: drops per lane.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= i_head_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_tag  <= n_a_tag;
            r_a_mag  <= n_mag;
            r_a_diag <= n_diag;
        end
    end

    // Stage B: slope weights; a diagonal drop is scaled by 1/sqrt(2).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_tag <= r_a_tag;
            for (int i = 0; i < NUM_DIRS; i++) begin
                if (r_a_diag[i]) begin
                    r_b_weight[i] <= WEIGHT_BITS'(r_a_mag[i]) * WEIGHT_BITS'(Q16_INV_SQRT2);
                end else begin
                    r_b_weight[i] <= {r_a_mag[i], 16'h0000};
                end
            end
        end
    end

    // Stage C: first two levels of the maximum tree; the higher index wins only
    // when strictly steeper, so ties keep the lower index.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_b_weight[2*k+1] > r_b_weight[2*k]) begin
                l1_w[k] = r_b_weight[2*k+1];
                l1_d[k] = DIR_BITS'(2*k+1);
            end else begin
                l1_w[k] = r_b_weight[2*k];
                l1_d[k] = DIR_BITS'(2*k);
            end
        end
        for (int k = 0; k < 2; k++) begin
            if (l1_w[2*k+1] > l1_w[2*k]) begin
                l2_w[k] = l1_w[2*k+1];
                l2_d[k] = l1_d[2*k+1];
            end else begin
                l2_w[k] = l1_w[2*k];
                l2_d[k] = l1_d[2*k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (advance) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_c_tag    <= r_b_tag;
            r_c_weight <= l2_w;
            r_c_dir    <= l2_d;
        end
    end

    // Last tree level into the output register; no positive slope means a sink.
    always_comb begin
        if (r_c_weight[1] > r_c_weight[0]) begin
            best_w = r_c_weight[1];
            best_d = r_c_dir[1];
        end else begin
            best_w = r_c_weight[0];
            best_d = r_c_dir[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_tag  <= r_c_tag;
            r_out_sink <= (best_w == '0);
            r_out_dir  <= (best_w == '0) ? '0 : best_d;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.cell_column    = r_out_tag.col;
    assign o_result.cell_row       = r_out_tag.row;
    assign o_result.flow_direction = r_out_dir;
    assign o_result.is_sink        = r_out_sink;
    assign o_result.last_of_run    = r_out_tag.last;
    assign o_result.grid_done      = r_out_tag.grid_done;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_tag.grid_done |-> r_out_tag.last)
        else $error("grid end result is not the last of its word");

    a_sink_dir_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_sink |-> r_out_dir == '0)
        else $error("sink result carries a direction");

    a_pending_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> pend != '0)
        else $error("queue head has no job left");

endmodule

[rtl/d8_flow_direction_raster.sv]
`timescale 1ns / 1ps
// Top level of the D8 flow direction block: configuration registers and wiring.
//
// Height words stream in on i_sample in raster order, one signed height per word,
// row by row with column 0 first. For every cell the block picks the neighbor of
// the eight-entry offset table with the steepest strictly downhill slope, or flags
// the cell as a sink, and sends one word per cell on o_result.
// Results lag by one row: a height word yields the result for the cell above-left
// of it, plus the cell above it at the end of a row; words of the last row also
// yield the results of that row, so the final word of a grid yields four results.
// Words of row 0 yield none.
// Throughput: one height word and one result word per cycle while o_result is
// ready. A row end or a last-row word yields two results and the final word four,
// so in the last row the front takes words only as the queue makes room. A result
// passes stage one, the queue and stages A, B and C to the output register. When
// the receiver stalls, the output register holds its word, the back end stops,
// the queue fills and i_sample.ready drops; nothing is lost.
// Reset clears the raster counters, the window and the queue and loads the
// configuration defaults; the line buffer is not cleared, as entries read before
// they are written only feed neighbors outside the grid.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata while idle.
module d8_flow_direction_raster (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    d8fd_sample_if.sink                           i_sample,
    d8fd_result_if.source                         o_result,
    input  logic                                  i_cfg_we,
    input  logic [d8fd_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [d8fd_pkg::CFG_DATA_BITS-1:0]    i_cfg_wdata
);
    import d8fd_pkg::*;

    logic [WIDTH_CFG_BITS-1:0] r_grid_width;
    logic [ROW_BITS-1:0]       r_grid_height;
    logic [OFFSETS_BITS-1:0]   r_neighbor_offsets;

    logic                      push;
    t_entry                    push_entry;
    logic                      pop;
    logic                      head_valid;
    t_entry                    head;
    logic [QCOUNT_BITS-1:0]    q_count;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width       <= GRID_WIDTH_RESET;
            r_grid_height      <= GRID_HEIGHT_RESET;
            r_neighbor_offsets <= OFFSETS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_wdata[WIDTH_CFG_BITS-1:0];
                end
                CFG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_wdata[ROW_BITS-1:0];
                end
                CFG_NEIGHBOR_OFFSETS: begin
                    r_neighbor_offsets <= i_cfg_wdata[OFFSETS_BITS-1:0];
                end
                default: begin
                    r_grid_width <= r_grid_width;
                end
            endcase
        end
    end

    // The front takes words, tracks the raster position and builds each window.
    d8fd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_grid_width  (r_grid_width),
        .i_grid_height (r_grid_height),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // Windows that cause results wait here until the back end gets to them.
    d8fd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head),
        .o_count (q_count)
    );

    // The back end drives o_result; it classifies one cell per cycle unless stalled.
    d8fd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_offsets    (r_neighbor_offsets),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_result     (o_result)
    );

endmodule

[dv/d8fd_flow_checker.sv]
`timescale 1ns / 1ps
// Checker for the D8 flow direction block: predicts every flow word and compares it.
module d8fd_flow_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    d8fd_sample_if                              i_sample,
    d8fd_result_if                              i_result,
    input  logic                                i_cfg_we,
    input  logic [d8fd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [d8fd_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_words_due,
    output int                                  o_result_count,
    output int                                  o_sink_count,
    output int                                  o_grid_count
);
    import d8fd_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef logic signed [HEIGHT_BITS-1:0] t_signed_height;

    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic [DIR_BITS-1:0] dir;
        logic                sink;
        logic                last;
        logic                done;
    } t_flow_word;

    // Private copy of the block state and its registers.
    t_signed_height            older_row [MAX_WIDTH];
    t_signed_height            newer_row [MAX_WIDTH];
    t_signed_height            win [WIN_CELLS];
    int                        col_count;
    int                        row_count;
    logic [WIDTH_CFG_BITS-1:0] width_reg;
    logic [ROW_BITS-1:0]       height_reg;
    logic [OFFSETS_BITS-1:0]   offsets_reg;

    t_flow_word flow_words_due [$];
    int         mismatches;
    int         results_seen;
    int         sinks_seen;
    int         grids_seen;

    function automatic int step_of(input logic [1:0] code);
        if (code == STEP_PLUS) return 1;
        if (code == STEP_MINUS) return -1;
        return 0;
    endfunction

    // Steepest strictly downhill neighbor of the window cell at (wc, wr).
    function automatic t_flow_word make_flow_word(input int wc, input int wr, input int cx,
                                                  input int cz, input int w, input int h);
        t_flow_word                  word;
        logic [3:0]                  code;
        int                          dx;
        int                          dz;
        int                          c;
        int                          r;
        logic signed [HEIGHT_BITS:0] self_h;
        logic signed [HEIGHT_BITS:0] nbr_h;
        logic signed [HEIGHT_BITS:0] drop;
        logic [2*HEIGHT_BITS:0]      weighted;
        logic [2*HEIGHT_BITS:0]      best;
        best   = '0;
        word   = '0;
        self_h = (HEIGHT_BITS+1)'(win[wr*3 + wc]);
        for (int i = 0; i < NUM_DIRS; i++) begin
            code = offsets_reg[4*i +: 4];
            dx   = step_of(code[1:0]);
            dz   = step_of(code[3:2]);
            c    = wc + dx;
            r    = wr + dz;
            if (dx == 0 && dz == 0) continue;
            if (cx + dx < 0 || cx + dx >= w || cz + dz < 0 || cz + dz >= h) continue;
            if (c < 0 || c > 2 || r < 0 || r > 2) continue;
            nbr_h = (HEIGHT_BITS+1)'(win[r*3 + c]);
            drop  = self_h - nbr_h;
            if (drop <= 0) continue;
            if (dx != 0 && dz != 0)
                weighted = (2*HEIGHT_BITS+1)'(drop[HEIGHT_BITS-1:0]) *
                           (2*HEIGHT_BITS+1)'(Q16_INV_SQRT2);
            else weighted = {1'b0, drop[HEIGHT_BITS-1:0], 16'h0000};
            if (weighted > best) begin
                best     = weighted;
                word.dir = i[DIR_BITS-1:0];
            end
        end
        word.col  = cx[COL_BITS-1:0];
        word.row  = cz[ROW_BITS-1:0];
        word.sink = (best == 0);
        word.done = (cx == w - 1 && cz == h - 1);
        return word;
    endfunction

    task automatic predict_height_word(input t_signed_height smp);
        int         w;
        int         h;
        int         x;
        int         z;
        int         n;
        t_flow_word batch [NUM_JOBS];
        w = int'(width_reg);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = int'(height_reg);
        if (h < 2) h = 2;
        if (col_count >= w) begin
            col_count = 0;
            row_count++;
        end
        if (row_count >= h) row_count = 0;
        x = col_count;
        z = row_count;

        for (int r = 0; r < 3; r++) begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2]       = older_row[x];
        win[5]       = newer_row[x];
        win[8]       = smp;
        older_row[x] = newer_row[x];
        newer_row[x] = smp;

        // The row above is finished cell by cell; the last row is finished as it streams.
        n = 0;
        if (z >= 1) begin
            if (x >= 1) begin
                batch[n] = make_flow_word(1, 1, x - 1, z - 1, w, h);
                n++;
            end
            if (x == w - 1) begin
                batch[n] = make_flow_word(2, 1, x, z - 1, w, h);
                n++;
            end
            if (z == h - 1) begin
                if (x >= 1) begin
                    batch[n] = make_flow_word(1, 2, x - 1, z, w, h);
                    n++;
                end
                if (x == w - 1) begin
                    batch[n] = make_flow_word(2, 2, x, z, w, h);
                    n++;
                end
            end
        end
        if (n > 0) batch[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) flow_words_due.push_back(batch[k]);

        col_count = x + 1;
        if (col_count >= w) begin
            col_count = 0;
            row_count = z + 1;
            if (row_count >= h) row_count = 0;
        end
    endtask

    task automatic report_flow_word(input string what, input t_flow_word want,
                                    input t_flow_word got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s at flow word %0d: expected col %0d row %0d dir %0d sink %0b",
                     what, results_seen, want.col, want.row, want.dir, want.sink,
                     " last %0b done %0b; got col %0d row %0d dir %0d sink %0b",
                     want.last, want.done, got.col, got.row, got.dir, got.sink,
                     " last %0b done %0b", got.last, got.done);
    endtask

    always @(posedge i_clk) begin
        t_flow_word got;
        t_flow_word want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WIDTH; k++) begin
                older_row[k] = '0;
                newer_row[k] = '0;
            end
            for (int k = 0; k < WIN_CELLS; k++) win[k] = '0;
            col_count    = 0;
            row_count    = 0;
            width_reg    = GRID_WIDTH_RESET;
            height_reg   = GRID_HEIGHT_RESET;
            offsets_reg  = OFFSETS_RESET;
            mismatches   = 0;
            results_seen = 0;
            sinks_seen   = 0;
            grids_seen   = 0;
            flow_words_due.delete();
        end else begin
            if (i_result.valid && i_result.ready) begin
                got.col  = i_result.cell_column;
                got.row  = i_result.cell_row;
                got.dir  = i_result.flow_direction;
                got.sink = i_result.is_sink;
                got.last = i_result.last_of_run;
                got.done = i_result.grid_done;
                if (flow_words_due.size() == 0) begin
                    report_flow_word("unexpected flow word", '0, got);
                end else begin
                    want = flow_words_due.pop_front();
                    if (want.sink) sinks_seen++;
                    if (want.done) grids_seen++;
                    if (got.col !== want.col || got.row !== want.row ||
                        got.dir !== want.dir || got.sink !== want.sink ||
                        got.last !== want.last || got.done !== want.done)
                        report_flow_word("flow word mismatch", want, got);
                end
                results_seen++;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRID_WIDTH:       width_reg   = i_cfg_wdata[WIDTH_CFG_BITS-1:0];
                    CFG_GRID_HEIGHT:      height_reg  = i_cfg_wdata[ROW_BITS-1:0];
                    CFG_NEIGHBOR_OFFSETS: offsets_reg = i_cfg_wdata[OFFSETS_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready) predict_height_word(i_sample.height_sample);
        end
        o_fail_count   <= mismatches;
        o_words_due    <= flow_words_due.size();
        o_result_count <= results_seen;
        o_sink_count   <= sinks_seen;
        o_grid_count   <= grids_seen;
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the D8 flow direction testbench: clock, reset, stimulus and verdict.
module tb_top;
    import d8fd_pkg::*;

    typedef logic signed [SAMPLE_BITS-1:0] t_signed_height;

    // Cycles without any accepted word before the run is declared hung. The slowest
    // correct stretch is a drain wait plus a few random stalls, far below this.
    localparam int STALL_LIMIT  = 4000;
    // Cycles granted after the last due flow word before registers change. Words of
    // row 0 yield nothing, so the pipeline and its queue may still hold some.
    localparam int DRAIN_CYCLES = 32;
    localparam int IDLE_PERCENT = 18;
    localparam int RANDOM_WORDS = 100;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;
    logic                      steady_flow;

    int fail_count;
    int words_due;
    int result_count;
    int sink_count;
    int grid_count;
    int stall_cycles;
    int words_sent;
    int settings_used;
    int random_words;

    d8fd_sample_if sample_ch ();
    d8fd_result_if result_ch ();

    d8_flow_direction_raster i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (sample_ch),
        .o_result    (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    d8fd_flow_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample       (sample_ch),
        .i_result       (result_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_words_due    (words_due),
        .o_result_count (result_count),
        .o_sink_count   (sink_count),
        .o_grid_count   (grid_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The receiver stalls at random, except while a steady stretch is running.
    always @(posedge i_clk) begin
        result_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Any accepted word on either channel shows the block is alive.
    always @(posedge i_clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    function automatic int clamp_width(input int raw);
        if (raw < 2) return 2;
        if (raw > MAX_WIDTH) return MAX_WIDTH;
        return raw;
    endfunction

    function automatic int clamp_height(input int raw);
        return (raw < 2) ? 2 : raw;
    endfunction

    // Half of the heights are drawn from a narrow band so that ties, flat spots and
    // sinks are common; the rest covers the full range and its extremes.
    function automatic t_signed_height pick_height();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return SAMPLE_BITS'(int'($urandom_range(0, 6)) - 3);
        if (sel < 80) return SAMPLE_BITS'($urandom());
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return 16'shFFFF;
        endcase
    endfunction

    // Offers one height word and returns at the edge where it is taken. Valid is
    // only lowered for a random gap, never between two back-to-back words.
    task automatic send_height(input t_signed_height value);
        if (!steady_flow) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                sample_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.height_sample <= value;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic stream_words(input int count);
        for (int k = 0; k < count; k++) send_height(pick_height());
    endtask

    // Waits until every predicted flow word has come back, then lets the pipeline
    // run dry before anything touches the registers.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (words_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all three registers back to back; the enable drops only after the last.
    task automatic program_grid(input int raw_w, input int raw_h,
                                input logic [OFFSETS_BITS-1:0] offsets);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_wdata <= raw_w;
        @(posedge i_clk);
        cfg_index <= CFG_GRID_HEIGHT;
        cfg_wdata <= raw_h;
        @(posedge i_clk);
        cfg_index <= CFG_NEIGHBOR_OFFSETS;
        cfg_wdata <= offsets;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // One setting, a whole number of grids, then a full drain.
    task automatic run_grids(input int raw_w, input int raw_h,
                             input logic [OFFSETS_BITS-1:0] offsets, input int grids);
        program_grid(raw_w, raw_h, offsets);
        stream_words(clamp_width(raw_w) * clamp_height(raw_h) * grids);
        wait_drained();
    endtask

    initial begin
        int raw_w;
        int raw_h;
        int grids;
        logic [OFFSETS_BITS-1:0] offsets;

        i_rst_n                 = 1'b0;
        sample_ch.valid         = 1'b0;
        sample_ch.height_sample = '0;
        cfg_we                  = 1'b0;
        cfg_index               = CFG_GRID_WIDTH;
        cfg_wdata               = '0;
        steady_flow             = 1'b0;
        words_sent              = 0;
        settings_used           = 0;
        random_words            = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A 3x3 grid in the default compass order: the height extremes, a raised
        // center, a flat stretch along the bottom row and a grid end on the final word.
        program_grid(3, 3, OFFSETS_RESET);
        send_height(16'sh7FFF); send_height(16'sh0000); send_height(16'sh0005);
        send_height(16'sh8000); send_height(16'sh0064); send_height(16'sh0064);
        send_height(16'sh0007); send_height(16'sh0007); send_height(16'shFFFF);
        wait_drained();

        // Width and height below the minimum are used as two, and a table of null
        // entries leaves every cell a sink however steep the ground is.
        program_grid(1, 0, '0);
        send_height(16'sh8000); send_height(16'sh7FFF);
        send_height(16'sh0001); send_height(16'shFFFE);
        wait_drained();

        // A table with null codes and repeated directions, so that a repeated entry
        // ties with an earlier one and the lower index must win. The grid is then
        // cut short mid-row: a narrower width starts a new row at once and the lower
        // height wraps that row back to zero.
        program_grid(4, 4, 32'h5F15_A0F1);
        send_height(16'sh0003); send_height(16'sh0003); send_height(16'sh0003);
        send_height(16'sh0003); send_height(16'sh0009); send_height(16'sh0003);
        wait_drained();
        program_grid(2, 2, 32'hD7C3_F451);
        send_height(16'sh0002); send_height(16'sh0001);
        send_height(16'sh0001); send_height(16'shFFF0);
        wait_drained();

        // Random small grids with random tables. The first setting runs without any
        // idling on either side; the rest gap and stall at random.
        steady_flow <= 1'b1;
        while (random_words < RANDOM_WORDS) begin
            raw_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
            raw_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
            case ($urandom_range(0, 3))
                0:       offsets = OFFSETS_RESET;
                default: offsets = $urandom();
            endcase
            grids = $urandom_range(1, 2);
            run_grids(raw_w, raw_h, offsets, grids);
            random_words += clamp_width(raw_w) * clamp_height(raw_h) * grids;
            steady_flow <= 1'b0;
        end

        // An oversized width falls back to the limit and a height below the minimum
        // to two; only the start of row 0 is streamed, so no flow word is due yet.
        program_grid(2047, 1, OFFSETS_RESET);
        stream_words(12);
        wait_drained();

        // The tallest height, streamed only partly; the column count is beyond the
        // new width, so a new row starts at once and the last row is never reached.
        program_grid(2, 65535, $urandom());
        stream_words(16);
        wait_drained();

        $display("Streamed %0d height words under %0d register settings, on rows from two",
                 words_sent, settings_used, " cells up to a clamped full width and heights up to 65535.");
        $display("Checked %0d flow words, %0d of them sinks, with %0d grid ends.",
                 result_count, sink_count, grid_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[d8_flow_direction_raster.f]
rtl/d8fd_pkg.sv
rtl/d8fd_if.sv
rtl/d8fd_front.sv
rtl/d8fd_queue.sv
rtl/d8fd_back.sv
rtl/d8_flow_direction_raster.sv
dv/d8fd_flow_checker.sv
dv/tb_top.sv
